// ----- rtl/atsj_pkg.sv -----
package atsj_pkg;

    typedef logic [1:0] t_set_sel;

    typedef struct packed {
        logic [7:0] lead;
        logic [7:0] trail;
    } t_sjis;

    // Graphic sets that can be invoked into GL or GR
    localparam t_set_sel SET_KANJI = 2'd0;
    localparam t_set_sel SET_ALNUM = 2'd1;
    localparam t_set_sel SET_HIRA  = 2'd2;
    localparam t_set_sel SET_KATA  = 2'd3;

    // Control codes
    localparam logic [7:0] CODE_LS1   = 8'h0E;
    localparam logic [7:0] CODE_LS0   = 8'h0F;
    localparam logic [7:0] CODE_SS2   = 8'h19;
    localparam logic [7:0] CODE_ESC   = 8'h1B;
    localparam logic [7:0] CODE_SS3   = 8'h1D;
    localparam logic [7:0] CODE_SPACE = 8'h20;
    localparam logic [7:0] CODE_MSZ   = 8'h89;
    localparam logic [7:0] CODE_NSZ   = 8'h8A;
    localparam logic [7:0] NONE_BYTE  = 8'h00;

    // Final bytes of the escape sequences
    localparam logic [7:0] ESC_LS2  = 8'h6E;
    localparam logic [7:0] ESC_LS3  = 8'h6F;
    localparam logic [7:0] ESC_LS3R = 8'h7C;
    localparam logic [7:0] ESC_LS2R = 8'h7D;
    localparam logic [7:0] ESC_LS1R = 8'h7E;

    localparam logic [15:0] JIS_SPACE = 16'h2121;

    function automatic logic is_gl(input logic [7:0] b);
        return (b >= 8'h21) && (b <= 8'h7E);
    endfunction

    function automatic logic is_gr(input logic [7:0] b);
        return (b >= 8'hA1) && (b <= 8'hFE);
    endfunction

    // JIS row of a one-byte set; zero for the two-byte kanji set
    function automatic logic [7:0] set_row(input t_set_sel sel);
        logic [7:0] row;
        unique case (sel)
            SET_KANJI: row = 8'h00;
            SET_ALNUM: row = 8'h23;
            SET_HIRA:  row = 8'h24;
            SET_KATA:  row = 8'h25;
            default:   row = 8'h00;
        endcase
        return row;
    endfunction

    function automatic logic [15:0] remap_symbol(input logic [15:0] jc);
        logic [15:0] r;
        unique case (jc)
            16'h2321: r = 16'h212A;
            16'h2328: r = 16'h214A;
            16'h2329: r = 16'h214B;
            16'h232D: r = 16'h215D;
            16'h232F: r = 16'h213F;
            16'h2479: r = 16'h213C;
            16'h2579: r = 16'h213C;
            16'h247E: r = 16'h2126;
            16'h257E: r = 16'h2126;
            default:  r = jc;
        endcase
        return r;
    endfunction

    function automatic t_sjis jis_to_sjis(input logic [15:0] jc);
        logic [7:0] hi;
        logic [7:0] lo;
        t_sjis      s;
        hi = jc[15:8];
        lo = jc[7:0];
        s.lead = ((hi - 8'h21) >> 1) + 8'h81;
        if (s.lead >= 8'hA0) begin
            s.lead = s.lead + 8'h40;
        end
        if (!hi[0]) begin
            s.trail = lo + 8'h7E;
        end else begin
            s.trail = lo + 8'h1F;
            if (s.trail >= 8'h7F) begin
                s.trail = s.trail + 8'h01;
            end
        end
        return s;
    endfunction

endpackage

// ----- rtl/atsj_if.sv -----
interface atsj_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       string_start;

    modport source (output valid, output code_byte, output string_start, input ready);
    modport sink   (input valid, input code_byte, input string_start, output ready);
endinterface

interface atsj_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] sjis_lead;
    logic [7:0] sjis_trail;

    modport source (output valid, output sjis_lead, output sjis_trail, input ready);
    modport sink   (input valid, input sjis_lead, input sjis_trail, output ready);
endinterface

// ----- rtl/arib_text_to_shift_jis.sv -----
// Channel   Direction  Carries                      Transfer
// i_byte    in         code_byte, string_start      valid && ready
// o_char    out        sjis_lead, sjis_trail        valid && ready
//
// One coded byte a cycle is accepted unless its character would land on a stalled result.
// The decode of one byte is a single pass from the input register into the result register,
// and the shift state updates in the same cycle, so the next byte decodes right behind it.
// Reset (synchronous, active low) empties both registers and restores GL=kanji, GR=hiragana.
// A stalled result holds only bytes that produce a character; control bytes keep flowing.
module arib_text_to_shift_jis
    import atsj_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    atsj_in_if.sink           i_byte,
    atsj_out_if.source        o_char
);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;

    // Decoder state
    logic [7:0] r_pending;
    t_set_sel   r_left;
    t_set_sel   r_right;
    t_set_sel   r_saved;
    logic       r_ss;

    // Result register
    logic       r_out_valid;
    t_sjis      r_out;

    // Next state and decode results
    logic [7:0]  n_pending;
    t_set_sel    n_left;
    t_set_sel    n_right;
    t_set_sel    n_saved;
    logic        n_ss;
    logic        w_emit;
    logic [15:0] w_jis;
    t_sjis       w_sjis;
    logic        w_adv;

    // Working copies of state: a string start restores reset values first
    logic [7:0] e_pending;
    t_set_sel   e_left;
    t_set_sel   e_right;
    t_set_sel   e_saved;
    logic       e_ss;

    always_comb begin
        if (r_in_start) begin
            e_pending = NONE_BYTE;
            e_left    = SET_KANJI;
            e_right   = SET_HIRA;
            e_saved   = SET_KANJI;
            e_ss      = 1'b0;
        end else begin
            e_pending = r_pending;
            e_left    = r_left;
            e_right   = r_right;
            e_saved   = r_saved;
            e_ss      = r_ss;
        end
    end

    // Decode one byte against the current shift state
    always_comb begin
        n_pending = NONE_BYTE;
        n_left    = e_left;
        n_right   = e_right;
        n_saved   = e_saved;
        n_ss      = e_ss;
        w_emit    = 1'b0;
        w_jis     = JIS_SPACE;

        if (e_pending == NONE_BYTE) begin
            priority if (r_in_byte == CODE_LS1) begin
                n_left = SET_ALNUM;
            end else if (r_in_byte == CODE_LS0) begin
                n_left = SET_KANJI;
            end else if (r_in_byte == CODE_SS2) begin
                n_saved = e_left;
                n_ss    = 1'b1;
                n_left  = SET_HIRA;
            end else if (r_in_byte == CODE_SS3) begin
                n_saved = e_left;
                n_ss    = 1'b1;
                n_left  = SET_KATA;
            end else if (r_in_byte == CODE_SPACE) begin
                w_emit = 1'b1;
                w_jis  = JIS_SPACE;
            end else if (r_in_byte == CODE_MSZ || r_in_byte == CODE_NSZ) begin
                // size controls: no effect
            end else if (is_gl(r_in_byte)) begin
                if (e_left != SET_KANJI) begin
                    w_emit = 1'b1;
                    w_jis  = {set_row(e_left), r_in_byte};
                end else begin
                    n_pending = r_in_byte;
                end
            end else if (is_gr(r_in_byte)) begin
                if (e_right != SET_KANJI) begin
                    w_emit = 1'b1;
                    w_jis  = {set_row(e_right), 1'b0, r_in_byte[6:0]};
                end else begin
                    n_pending = r_in_byte;
                end
            end else begin
                // unknown byte: hold it and drop it with the next one
                n_pending = r_in_byte;
            end
        end else begin
            priority if (e_pending == CODE_ESC && r_in_byte == ESC_LS2) begin
                n_left = SET_HIRA;
            end else if (e_pending == CODE_ESC && r_in_byte == ESC_LS3) begin
                n_left = SET_KATA;
            end else if (e_pending == CODE_ESC && r_in_byte == ESC_LS3R) begin
                n_right = SET_KATA;
            end else if (e_pending == CODE_ESC && r_in_byte == ESC_LS2R) begin
                n_right = SET_HIRA;
            end else if (e_pending == CODE_ESC && r_in_byte == ESC_LS1R) begin
                n_right = SET_ALNUM;
            end else if (is_gl(e_pending)) begin
                if (is_gl(r_in_byte) && e_left == SET_KANJI) begin
                    w_emit = 1'b1;
                    w_jis  = {e_pending, r_in_byte};
                end
            end else if (is_gr(e_pending)) begin
                if (is_gr(r_in_byte) && e_right == SET_KANJI) begin
                    w_emit = 1'b1;
                    w_jis  = {1'b0, e_pending[6:0], 1'b0, r_in_byte[6:0]};
                end
            end else begin
                // unknown pair: drop
            end
        end

        // A character ends an active single shift
        if (w_emit && e_ss) begin
            n_left = e_saved;
            n_ss   = 1'b0;
        end
    end

    assign w_sjis = jis_to_sjis(remap_symbol(w_jis));

    // Advance the held byte unless its character would land on a stalled result
    assign w_adv = r_in_valid && (!w_emit || !r_out_valid || o_char.ready);

    assign i_byte.ready     = !r_in_valid || w_adv;
    assign o_char.valid     = r_out_valid;
    assign o_char.sjis_lead  = r_out.lead;
    assign o_char.sjis_trail = r_out.trail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pending   <= NONE_BYTE;
            r_left      <= SET_KANJI;
            r_right     <= SET_HIRA;
            r_saved     <= SET_KANJI;
            r_ss        <= 1'b0;
        end else begin
            if (i_byte.valid && i_byte.ready) begin
                r_in_valid <= 1'b1;
                r_in_byte  <= i_byte.code_byte;
                r_in_start <= i_byte.string_start;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end

            if (w_adv) begin
                r_pending <= n_pending;
                r_left    <= n_left;
                r_right   <= n_right;
                r_saved   <= n_saved;
                r_ss      <= n_ss;
            end

            if (w_adv && w_emit) begin
                r_out_valid <= 1'b1;
                r_out       <= w_sjis;
            end else if (o_char.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/atsj_checker.sv -----
module atsj_checker
    import atsj_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [7:0] i_code_byte,
    input logic       i_string_start,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_sjis_lead,
    input logic [7:0] i_sjis_trail
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_sjis_lead)
            && $stable(i_sjis_trail))
        else $error("stalled result changed");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A fresh result follows an accepted request, through the input and result registers
    a_rise_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result without a request");

    // A space opening a string decodes to the full-width space
    a_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_string_start && i_code_byte == CODE_SPACE)
            ##1 (!i_out_valid || i_out_ready)
        |=> i_out_valid && i_sjis_lead == 8'h81 && i_sjis_trail == 8'h40)
        else $error("space decoded wrongly");

endmodule

bind arib_text_to_shift_jis atsj_checker u_atsj_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_byte.valid),
    .i_in_ready     (i_byte.ready),
    .i_code_byte    (i_byte.code_byte),
    .i_string_start (i_byte.string_start),
    .i_out_valid    (o_char.valid),
    .i_out_ready    (o_char.ready),
    .i_sjis_lead    (o_char.sjis_lead),
    .i_sjis_trail   (o_char.sjis_trail)
);

// ----- tb/arib_text_to_shift_jis_test.sv -----
`timescale 1ns / 100ps

// Drive ARIB 8-unit coded bytes into the decoder and check every Shift-JIS
// character that leaves it. A local decoder model follows each accepted
// request and queues the character it should produce. A checker process
// compares each delivered character with the oldest queued one.
module arib_text_to_shift_jis_test;
    import atsj_pkg::*;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // 8 ns clock period
    always #4 i_clk = ~i_clk;

    atsj_in_if  req_if ();
    atsj_out_if char_if ();

    arib_text_to_shift_jis DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (req_if),
        .o_char  (char_if)
    );

    // Idle rates in percent for the request side and the character side
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    int          requests_sent  = 0;
    int          mismatch_count = 0;

    // Characters the decoder still owes, oldest first
    t_sjis       expected_chars[$];
    t_sjis       want_char;

    // Decoder model state
    logic [7:0]  held_byte;
    t_set_sel    gl_set;
    t_set_sel    gr_set;
    t_set_sel    gl_restore;
    logic        shift_once;

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    function automatic void clear_decoder();
        held_byte  = NONE_BYTE;
        gl_set     = SET_KANJI;
        gr_set     = SET_HIRA;
        gl_restore = SET_KANJI;
        shift_once = 1'b0;
    endfunction

    // JIS row of a one-byte set: alnum 0x23, hiragana 0x24, katakana 0x25.
    // Zero marks the two-byte kanji set.
    function automatic logic [7:0] one_byte_row(input t_set_sel sel);
        return (sel == SET_KANJI) ? 8'h00 : 8'h22 + 8'(sel);
    endfunction

    // Swap the nine ARIB symbols for their JIS X 0208 equivalents
    function automatic logic [15:0] substitute_symbol(input logic [15:0] jc);
        logic [15:0] subst;
        subst = jc;
        if (jc[15:8] == 8'h23) begin
            case (jc[7:0])
                8'h21:   subst = 16'h212A;
                8'h28:   subst = 16'h214A;
                8'h29:   subst = 16'h214B;
                8'h2D:   subst = 16'h215D;
                8'h2F:   subst = 16'h213F;
                default: ;
            endcase
        end else if (jc[15:8] == 8'h24 || jc[15:8] == 8'h25) begin
            // prolonged sound mark and middle dot of both kana sets
            if (jc[7:0] == 8'h79) subst = 16'h213C;
            if (jc[7:0] == 8'h7E) subst = 16'h2126;
        end
        return subst;
    endfunction

    // Work from zero-based row and column: two JIS rows share one lead byte,
    // odd rows take the upper trail range, even rows skip 0x7F.
    function automatic t_sjis jis_pair_to_sjis(input logic [15:0] jc);
        logic [7:0] row;
        logic [7:0] col;
        t_sjis      pair;
        row = jc[15:8] - 8'h21;
        col = jc[7:0] - 8'h21;
        pair.lead = 8'h81 + (row >> 1);
        if (row >= 8'h3E) pair.lead = pair.lead + 8'h40;
        if (row[0]) begin
            pair.trail = 8'h9F + col;
        end else begin
            pair.trail = 8'h40 + col;
            if (col >= 8'h3F) pair.trail = pair.trail + 8'h01;
        end
        return pair;
    endfunction

    // Advance the model by one accepted request and queue any character
    function automatic void decode_byte(input logic [7:0] code, input logic first);
        logic [15:0] jc;
        logic [7:0]  next_held;
        logic [7:0]  row;
        jc        = 16'h0000;
        next_held = NONE_BYTE;
        if (first) clear_decoder();

        if (held_byte == NONE_BYTE) begin
            case (code)
                CODE_LS1:   gl_set = SET_ALNUM;
                CODE_LS0:   gl_set = SET_KANJI;
                CODE_SS2: begin
                    gl_restore = gl_set;
                    shift_once = 1'b1;
                    gl_set     = SET_HIRA;
                end
                CODE_SS3: begin
                    gl_restore = gl_set;
                    shift_once = 1'b1;
                    gl_set     = SET_KATA;
                end
                CODE_SPACE: jc = JIS_SPACE;
                CODE_MSZ, CODE_NSZ: ;
                default: begin
                    if (code >= 8'h21 && code <= 8'h7E) begin
                        row = one_byte_row(gl_set);
                        if (row != 8'h00) jc = {row, code};
                        else next_held = code;
                    end else if (code >= 8'hA1 && code <= 8'hFE) begin
                        row = one_byte_row(gr_set);
                        if (row != 8'h00) jc = {row, 1'b0, code[6:0]};
                        else next_held = code;
                    end else begin
                        // unknown byte: hold it so the next byte is dropped with it
                        next_held = code;
                    end
                end
            endcase
        end else if (held_byte == CODE_ESC) begin
            case (code)
                ESC_LS2:  gl_set = SET_HIRA;
                ESC_LS3:  gl_set = SET_KATA;
                ESC_LS3R: gr_set = SET_KATA;
                ESC_LS2R: gr_set = SET_HIRA;
                ESC_LS1R: gr_set = SET_ALNUM;
                default:  ;
            endcase
        end else if (held_byte >= 8'h21 && held_byte <= 8'h7E) begin
            if (code >= 8'h21 && code <= 8'h7E && gl_set == SET_KANJI)
                jc = {held_byte, code};
        end else if (held_byte >= 8'hA1 && held_byte <= 8'hFE) begin
            if (code >= 8'hA1 && code <= 8'hFE && gr_set == SET_KANJI)
                jc = {1'b0, held_byte[6:0], 1'b0, code[6:0]};
        end
        held_byte = next_held;

        if (jc != 16'h0000) begin
            expected_chars.push_back(jis_pair_to_sjis(substitute_symbol(jc)));
            // any emitted character ends a single shift
            if (shift_once) begin
                gl_set     = gl_restore;
                shift_once = 1'b0;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one request from a falling edge; hold it until accepted.
    // Leave valid high on return so back-to-back requests need no gap.
    task automatic send_byte(input logic [7:0] code, input logic first);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.code_byte    <= code;
        req_if.string_start <= first;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        decode_byte(code, first);
        requests_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and hold off until every owed character has arrived
    task automatic hold_requests();
        req_if.valid <= 1'b0;
        @(negedge i_clk);
        while (expected_chars.size() != 0) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Character side
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        char_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t ns: %s: got %02h, want %02h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Compare every delivered character with the oldest owed one
    always @(posedge i_clk) begin
        if (i_rst_n && char_if.valid && char_if.ready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch("unexpected character, lead", char_if.sjis_lead, 8'h00);
            end else begin
                want_char = expected_chars.pop_front();
                if (char_if.sjis_lead !== want_char.lead)
                    report_mismatch("lead byte", char_if.sjis_lead, want_char.lead);
                if (char_if.sjis_trail !== want_char.trail)
                    report_mismatch("trail byte", char_if.sjis_trail, want_char.trail);
            end
        end
    end

    // ------------------------------------------------------------------
    // Random stimulus helpers
    // ------------------------------------------------------------------

    // Low bytes that hit the symbol substitutions in the one-byte sets
    function automatic logic [7:0] pick_symbol_low();
        case ($urandom_range(6))
            0:       return 8'h21;
            1:       return 8'h28;
            2:       return 8'h29;
            3:       return 8'h2D;
            4:       return 8'h2F;
            5:       return 8'h79;
            default: return 8'h7E;
        endcase
    endfunction

    function automatic logic [7:0] pick_escape_final();
        case ($urandom_range(4))
            0:       return ESC_LS2;
            1:       return ESC_LS3;
            2:       return ESC_LS3R;
            3:       return ESC_LS2R;
            default: return ESC_LS1R;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Space, default GR hiragana, LS1 into alnum with its symbols
    task automatic test_one_byte_sets();
        send_byte(CODE_SPACE, 1'b1);
        send_byte(8'hFE, 1'b0);      // hiragana middle dot
        send_byte(CODE_LS1, 1'b0);
        send_byte(8'h2F, 1'b0);      // alnum slash is remapped
        send_byte(8'h7E, 1'b0);
    endtask

    // Every escape final; each but LS2R is proven by a character in the new set
    task automatic test_escape_sequences();
        send_byte(CODE_ESC, 1'b0);
        send_byte(ESC_LS3, 1'b0);
        send_byte(8'h79, 1'b0);      // katakana prolonged sound mark
        send_byte(CODE_ESC, 1'b0);
        send_byte(ESC_LS3R, 1'b0);
        send_byte(8'hA1, 1'b0);
        send_byte(CODE_ESC, 1'b0);
        send_byte(ESC_LS1R, 1'b0);
        send_byte(8'hA1, 1'b0);      // GR alnum exclamation is remapped
        send_byte(CODE_ESC, 1'b0);
        send_byte(ESC_LS2, 1'b0);
        send_byte(CODE_ESC, 1'b0);
        send_byte(ESC_LS2R, 1'b0);
        send_byte(8'h21, 1'b0);
    endtask

    // Highest kanji, then a kanji lead with a bad second byte
    task automatic test_kanji_pairs();
        send_byte(CODE_LS0, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(8'h21, 1'b0);
        send_byte(CODE_MSZ, 1'b0);   // unknown pair: no character
    endtask

    // Repeated single shift keeps the shifted set; space ends the shift
    task automatic test_single_shifts();
        send_byte(CODE_SS2, 1'b1);
        send_byte(8'h21, 1'b0);
        send_byte(CODE_SS3, 1'b0);
        send_byte(CODE_SS3, 1'b0);
        send_byte(CODE_SPACE, 1'b0);
        send_byte(8'h7E, 1'b0);      // GL stays katakana
    endtask

    // Size codes pass silently; an unknown byte swallows the next one
    task automatic test_unknown_and_size_codes();
        send_byte(CODE_NSZ, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(NONE_BYTE, 1'b0);
        send_byte(8'h80, 1'b0);
    endtask

    // Mostly well-formed text with random content, some broken pairs and noise
    task automatic test_random_text(input int n_items);
        int         stop_at;
        int         kind;
        logic       first;
        logic [7:0] code;
        t_set_sel   gl_now;
        stop_at = requests_sent + n_items;
        while (requests_sent < stop_at) begin
            first  = ($urandom_range(19) == 0);
            gl_now = first ? SET_KANJI : gl_set;
            kind   = $urandom_range(99);
            if (kind < 10) begin
                send_byte($urandom_range(1) ? CODE_LS0 : CODE_LS1, first);
            end else if (kind < 20) begin
                send_byte(CODE_ESC, first);
                code = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : pick_escape_final();
                send_byte(code, 1'b0);
            end else if (kind < 28) begin
                send_byte($urandom_range(1) ? CODE_SS2 : CODE_SS3, first);
            end else if (kind < 32) begin
                send_byte($urandom_range(1) ? CODE_MSZ : CODE_NSZ, first);
            end else if (kind < 38) begin
                send_byte(CODE_SPACE, first);
            end else if (kind < 70) begin
                code = ($urandom_range(3) == 0) ? pick_symbol_low() : 8'($urandom_range(33, 126));
                send_byte(code, first);
                // a kanji needs its second byte; break a few on purpose
                if (gl_now == SET_KANJI) begin
                    code = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                    : 8'($urandom_range(33, 126));
                    send_byte(code, 1'b0);
                end
            end else if (kind < 90) begin
                code = ($urandom_range(3) == 0) ? (pick_symbol_low() | 8'h80)
                                                : 8'($urandom_range(161, 254));
                send_byte(code, first);
            end else begin
                send_byte(8'($urandom_range(255)), first);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        req_if.valid        = 1'b0;
        req_if.code_byte    = 8'h00;
        req_if.string_start = 1'b0;
        clear_decoder();

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // sender idles less than the receiver
        send_idle_pct = 28;
        recv_idle_pct = 49;
        test_one_byte_sets();
        test_escape_sequences();
        test_kanji_pairs();
        test_single_shifts();
        test_unknown_and_size_codes();
        hold_requests();
        test_random_text(280);
        hold_requests();

        // receiver idles less than the sender
        send_idle_pct = 49;
        recv_idle_pct = 28;
        test_random_text(280);
        hold_requests();

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_text(290);
        hold_requests();

        // let any trailing decode settle before the verdict
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
